/* src/q2e_pkg.sv */
`default_nettype none
package q2e_pkg;

    // Quaternion component and angle widths.
    localparam int QUAT_W  = 16;
    localparam int ANGLE_W = 16;

    // Sine and cosine terms at Q.30, with headroom for non-unit inputs.
    localparam int TERM_W = 34;

    // Radicand 1 - s*s at Q.60 and its square root at Q.30.
    localparam int RAD_W  = 61;
    localparam int ROOT_W = 31;

    // CORDIC vector width and angle accumulator width (2^31 = pi).
    localparam int CORDIC_W = 36;
    localparam int ACC_W    = 34;

    // Default number of CORDIC iterations and the table length.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    // Binary angle of pi/2 on the output scale.
    localparam logic signed [ANGLE_W-1:0] HALF_PI = 16'sd16384;

    // 1.0 at Q.30.
    localparam logic signed [TERM_W-1:0] ONE_Q30 = 34'sd1073741824;

    // round(atan(2^-i) / pi * 2^31).
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Sine and cosine terms of the three angles.
    typedef struct packed {
        logic signed [TERM_W-1:0] sinr;
        logic signed [TERM_W-1:0] cosr;
        logic signed [TERM_W-1:0] sinp;
        logic signed [TERM_W-1:0] siny;
        logic signed [TERM_W-1:0] cosy;
    } t_terms;

    // Pitch saturation status.
    typedef struct packed {
        logic clamp;
        logic neg;
    } t_flags;

    // Data that rides alongside the square root unit.
    typedef struct packed {
        t_terms terms;
        t_flags flags;
    } t_sq_side;

endpackage
`default_nettype wire

/* src/q2e_terms.sv */
`default_nettype none
module q2e_terms (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_en,
    input  wire                                    i_valid,
    input  wire signed [q2e_pkg::QUAT_W-1:0]       i_x,
    input  wire signed [q2e_pkg::QUAT_W-1:0]       i_y,
    input  wire signed [q2e_pkg::QUAT_W-1:0]       i_z,
    input  wire signed [q2e_pkg::QUAT_W-1:0]       i_w,
    output logic                                   o_valid,
    output q2e_pkg::t_terms                        o_terms,
    output q2e_pkg::t_flags                        o_flags,
    output logic [q2e_pkg::RAD_W-1:0]              o_rad
);
    import q2e_pkg::*;

    localparam int PW = 2 * QUAT_W;

    logic [2:0] r_valid;

    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    t_terms r_terms;
    t_flags r_flags;
    t_terms n_terms;
    t_flags n_flags;

    t_terms r_terms2;
    t_flags r_flags2;
    logic [RAD_W-1:0] r_rad;

    logic signed [ROOT_W-1:0]   sp;
    logic signed [2*ROOT_W-1:0] sq;
    logic [RAD_W-1:0]           n_rad;

    // Sums of products form the Q.30 terms; pitch saturation is found here.
    always_comb begin
        n_terms.sinr = (TERM_W'(r_wx) + TERM_W'(r_yz)) <<< 1;
        n_terms.cosr = ONE_Q30 - ((TERM_W'(r_xx) + TERM_W'(r_yy)) <<< 1);
        n_terms.sinp = (TERM_W'(r_wy) - TERM_W'(r_zx)) <<< 1;
        n_terms.siny = (TERM_W'(r_wz) + TERM_W'(r_xy)) <<< 1;
        n_terms.cosy = ONE_Q30 - ((TERM_W'(r_yy) + TERM_W'(r_zz)) <<< 1);
        n_flags.clamp = (n_terms.sinp >= ONE_Q30) || (n_terms.sinp <= -ONE_Q30);
        n_flags.neg   = n_terms.sinp[TERM_W-1];
    end

    // Radicand 1 - s*s; only meaningful when the pitch term is in range.
    always_comb begin
        sp = r_terms.sinp[ROOT_W-1:0];
        sq = sp * sp;
        if (r_flags.clamp) begin
            n_rad = '0;
        end else begin
            n_rad = (RAD_W'(1) << (RAD_W - 1)) - sq[RAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Three stages: products, sums, square.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
            r_terms  <= n_terms;
            r_flags  <= n_flags;
            r_terms2 <= r_terms;
            r_flags2 <= r_flags;
            r_rad    <= n_rad;
        end
    end

    assign o_valid = r_valid[2];
    assign o_terms = r_terms2;
    assign o_flags = r_flags2;
    assign o_rad   = r_rad;

endmodule
`default_nettype wire

/* src/q2e_isqrt.sv */
`default_nettype none
module q2e_isqrt #(
    parameter int SW = 1
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_valid,
    input  wire [q2e_pkg::RAD_W-1:0]           i_rad,
    input  wire [SW-1:0]                       i_side,
    output logic                               o_valid,
    output logic [q2e_pkg::ROOT_W-1:0]         o_root,
    output logic [SW-1:0]                      o_side
);
    import q2e_pkg::*;

    localparam int NB = ROOT_W;
    localparam int TW = RAD_W + 2;

    logic [RAD_W-1:0]  rem_q  [0:NB];
    logic [ROOT_W-1:0] root_q [0:NB];
    logic [SW-1:0]     side_q [0:NB];
    logic              vld_q  [0:NB];

    assign rem_q[0]  = i_rad;
    assign root_q[0] = '0;
    assign side_q[0] = i_side;
    assign vld_q[0]  = i_valid;

    // One result bit per stage, most significant first.
    for (genvar k = 0; k < NB; k++) begin : g_bit
        localparam int B = NB - 1 - k;

        logic [TW-1:0]     trial;
        logic [TW-1:0]     rem_ext;
        logic              take;
        logic [RAD_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [SW-1:0]     r_side;
        logic              r_vld;

        always_comb begin
            trial   = (TW'(root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
            rem_ext = TW'(rem_q[k]);
            take    = rem_ext >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= vld_q[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= side_q[k];
                if (take) begin
                    r_rem  <= RAD_W'(rem_ext - trial);
                    r_root <= root_q[k] | (ROOT_W'(1) << B);
                end else begin
                    r_rem  <= rem_q[k];
                    r_root <= root_q[k];
                end
            end
        end

        assign rem_q[k+1]  = r_rem;
        assign root_q[k+1] = r_root;
        assign side_q[k+1] = r_side;
        assign vld_q[k+1]  = r_vld;
    end

    assign o_valid = vld_q[NB];
    assign o_root  = root_q[NB];
    assign o_side  = side_q[NB];

endmodule
`default_nettype wire

/* src/q2e_cordic.sv */
`default_nettype none
module q2e_cordic #(
    parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire signed [q2e_pkg::TERM_W-1:0]     i_y,
    input  wire signed [q2e_pkg::TERM_W-1:0]     i_x,
    output logic                                 o_valid,
    output logic                                 o_zero,
    output logic signed [q2e_pkg::ACC_W-1:0]     o_acc
);
    import q2e_pkg::*;

    logic signed [CORDIC_W-1:0] xs [0:STAGES];
    logic signed [CORDIC_W-1:0] ys [0:STAGES];
    logic signed [ACC_W-1:0]    as [0:STAGES];
    logic                       zs [0:STAGES];
    logic                       vs [0:STAGES];

    logic signed [CORDIC_W-1:0] xe, ye;
    logic signed [CORDIC_W-1:0] r_x0, r_y0, n_x0, n_y0;
    logic signed [ACC_W-1:0]    r_a0, n_a0;
    logic                       r_z0, r_v0;

    // Pre-rotation by a quarter turn brings the vector into the right half plane.
    always_comb begin
        xe = CORDIC_W'(i_x);
        ye = CORDIC_W'(i_y);
        n_x0 = xe;
        n_y0 = ye;
        n_a0 = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x0 = ye;
                n_y0 = -xe;
                n_a0 = ACC_W'(1) <<< 30;
            end else begin
                n_x0 = -ye;
                n_y0 = xe;
                n_a0 = -(ACC_W'(1) <<< 30);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_a0 <= n_a0;
            r_z0 <= (i_x == '0) && (i_y == '0);
        end
    end

    assign xs[0] = r_x0;
    assign ys[0] = r_y0;
    assign as[0] = r_a0;
    assign zs[0] = r_z0;
    assign vs[0] = r_v0;

    // One micro-rotation per stage toward the x axis.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CORDIC_W-1:0] dx, dy;
        logic signed [ACC_W-1:0]    tab;
        logic signed [CORDIC_W-1:0] r_x, r_y;
        logic signed [ACC_W-1:0]    r_a;
        logic                       r_z, r_v;

        always_comb begin
            dx  = ys[k] >>> k;
            dy  = xs[k] >>> k;
            tab = signed'(ACC_W'(ATAN_TAB[k]));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= vs[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z <= zs[k];
                if (!ys[k][CORDIC_W-1]) begin
                    r_x <= xs[k] + dx;
                    r_y <= ys[k] - dy;
                    r_a <= as[k] + tab;
                end else begin
                    r_x <= xs[k] - dx;
                    r_y <= ys[k] + dy;
                    r_a <= as[k] - tab;
                end
            end
        end

        assign xs[k+1] = r_x;
        assign ys[k+1] = r_y;
        assign as[k+1] = r_a;
        assign zs[k+1] = r_z;
        assign vs[k+1] = r_v;
    end

    assign o_valid = vs[STAGES];
    assign o_zero  = zs[STAGES];
    assign o_acc   = as[STAGES];

endmodule
`default_nettype wire

/* src/quaternion_to_euler.sv */
// Quaternion to ZYX Euler angle converter.
// Input channel (s side): one unit quaternion per transfer, Q1.15 components
// packed x, y, z, w from the low bits of i_s_tdata.
// Output channel (m side): roll, pitch and yaw as 16-bit binary angles
// (32768 = pi) packed from the low bits of o_m_tdata; o_m_tuser is set when
// the pitch sine term reached magnitude one and pitch was saturated.
// Throughput: one quaternion per cycle while the receiver does not stall.
// Pipeline order: products and terms, the bit-per-stage square root used by
// the pitch path, CORDIC pre-rotation, the CORDIC iterations and the output
// register. Roll and yaw ride alongside the square root.
// Reset clears all valid bits; the pipeline then holds no items.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_tready falls; while the output register is empty, items keep
// moving in even with i_m_tready low, so no bubbles are kept.
`default_nettype none
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,  // quat_x, quat_y, quat_z, quat_w
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic        o_m_tuser   // pitch_clamped
);
    import q2e_pkg::*;

    localparam int BW = ACC_W - 16;

    logic en;

    logic signed [QUAT_W-1:0] qx, qy, qz, qw;

    logic             t_valid;
    t_terms           t_trm;
    t_flags           t_flg;
    logic [RAD_W-1:0] t_rad;

    t_sq_side          sq_in, sq_out;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;

    logic                    c_valid, cp_valid, cy_valid;
    logic                    r_zero, p_zero, y_zero;
    logic signed [ACC_W-1:0] r_acc, p_acc, y_acc;

    t_flags r_fl [0:CORDIC_STAGES];

    logic                      r_m_tvalid;
    logic [47:0]               r_m_tdata;
    logic                      r_m_tuser;
    logic signed [ANGLE_W-1:0] n_roll, n_pitch, n_yaw;
    logic signed [ACC_W-1:0]   rr, pr, yr;
    logic signed [BW-1:0]      pb;

    // The pipeline moves whenever the output register is free or is taken.
    assign en         = !r_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    assign qx = i_s_tdata[15:0];
    assign qy = i_s_tdata[31:16];
    assign qz = i_s_tdata[47:32];
    assign qw = i_s_tdata[63:48];

    q2e_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_x     (qx),
        .i_y     (qy),
        .i_z     (qz),
        .i_w     (qw),
        .o_valid (t_valid),
        .o_terms (t_trm),
        .o_flags (t_flg),
        .o_rad   (t_rad)
    );

    assign sq_in.terms = t_trm;
    assign sq_in.flags = t_flg;

    q2e_isqrt #(
        .SW ($bits(t_sq_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (t_valid),
        .i_rad   (t_rad),
        .i_side  (sq_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_out)
    );

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_y     (sq_out.terms.sinr),
        .i_x     (sq_out.terms.cosr),
        .o_valid (c_valid),
        .o_zero  (r_zero),
        .o_acc   (r_acc)
    );

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_y     (sq_out.terms.sinp),
        .i_x     (TERM_W'(sq_root)),
        .o_valid (cp_valid),
        .o_zero  (p_zero),
        .o_acc   (p_acc)
    );

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_y     (sq_out.terms.siny),
        .i_x     (sq_out.terms.cosy),
        .o_valid (cy_valid),
        .o_zero  (y_zero),
        .o_acc   (y_acc)
    );

    // Pitch saturation flags follow the CORDIC latency.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl[0] <= sq_out.flags;
            for (int i = 1; i <= CORDIC_STAGES; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    // Round accumulators to 16-bit binary angles and apply the pitch limits.
    always_comb begin
        rr = (r_acc + ACC_W'(32768)) >>> 16;
        pr = (p_acc + ACC_W'(32768)) >>> 16;
        yr = (y_acc + ACC_W'(32768)) >>> 16;
        pb = pr[BW-1:0];

        n_roll = r_zero ? '0 : rr[ANGLE_W-1:0];
        n_yaw  = y_zero ? '0 : yr[ANGLE_W-1:0];

        if (r_fl[CORDIC_STAGES].clamp) begin
            n_pitch = r_fl[CORDIC_STAGES].neg ? -HALF_PI : HALF_PI;
        end else if (p_zero) begin
            n_pitch = '0;
        end else if (pb > BW'(HALF_PI)) begin
            n_pitch = HALF_PI;
        end else if (pb < -BW'(HALF_PI)) begin
            n_pitch = -HALF_PI;
        end else begin
            n_pitch = pb[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (en) begin
            r_m_tvalid <= c_valid && cp_valid && cy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_tdata <= {n_yaw, n_pitch, n_roll};
            r_m_tuser <= r_fl[CORDIC_STAGES].clamp;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;

    import q2e_pkg::*;

    localparam int STAGES     = CORDIC_STAGES_DEF;
    localparam int LATENCY    = 36 + STAGES;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 1230;

    // Expected output of one conversion.
    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;

    // Holds predicted angles and checks them against received transfers.
    class angle_scoreboard;
        t_angles pending[$];
        int      errors;

        // floor(v / 2^s) on signed values.
        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        // Vectoring CORDIC, accumulator scaled so 2^31 = pi.
        static function longint vector_angle(longint yv, longint xv);
            longint acc;
            longint t;
            longint dx;
            longint dy;
            acc = 0;
            if (xv == 0 && yv == 0) return 0;
            if (xv < 0) begin
                if (yv >= 0) begin
                    t = xv; xv = yv; yv = -t; acc = 64'sd1 <<< 30;
                end else begin
                    t = xv; xv = -yv; yv = t; acc = -(64'sd1 <<< 30);
                end
            end
            for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
                dx = floor_shift(yv, i);
                dy = floor_shift(xv, i);
                if (yv >= 0) begin
                    xv += dx; yv -= dy; acc += longint'(ATAN_TAB[i]);
                end else begin
                    xv -= dx; yv += dy; acc -= longint'(ATAN_TAB[i]);
                end
            end
            return acc;
        endfunction

        static function longint to_angle(longint acc);
            return floor_shift(acc + 32768, 16);
        endfunction

        // Bitwise integer square root.
        static function longint int_root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function void note_input(logic [63:0] d);
            longint qx, qy, qz, qw, sinp, sq, c, p, one;
            t_angles e;
            one = 64'sd1 <<< 30;
            qx = longint'($signed(d[15:0]));
            qy = longint'($signed(d[31:16]));
            qz = longint'($signed(d[47:32]));
            qw = longint'($signed(d[63:48]));
            e.roll = 16'(to_angle(vector_angle(2 * (qw * qx + qy * qz),
                                                one - 2 * (qx * qx + qy * qy))));
            e.yaw  = 16'(to_angle(vector_angle(2 * (qw * qz + qx * qy),
                                                one - 2 * (qy * qy + qz * qz))));
            sinp = 2 * (qw * qy - qz * qx);
            e.clamped = 1'b0;
            if (sinp >= one) begin
                p = 16384; e.clamped = 1'b1;
            end else if (sinp <= -one) begin
                p = -16384; e.clamped = 1'b1;
            end else begin
                sq = sinp * sinp;
                c = int_root(longint'(64'd1 << 60) - sq);
                p = to_angle(vector_angle(sinp, c));
                if (p > 16384) p = 16384;
                if (p < -16384) p = -16384;
            end
            e.pitch = 16'(p);
            pending.push_back(e);
        endfunction

        function void check_output(logic [47:0] d, logic flag);
            t_angles e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, d, flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.roll) begin
                $display("%0t: roll expected %0d actual %0d", $time, e.roll,
                         $signed(d[15:0]));
                errors++;
            end
            if (d[31:16] !== e.pitch) begin
                $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                         $signed(d[31:16]));
                errors++;
            end
            if (d[47:32] !== e.yaw) begin
                $display("%0t: yaw expected %0d actual %0d", $time, e.yaw,
                         $signed(d[47:32]));
                errors++;
            end
            if (flag !== e.clamped) begin
                $display("%0t: clamp expected %b actual %b", $time, e.clamped, flag);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // roll_angle, pitch_angle, yaw_angle
    logic        o_m_tuser;   // pitch_clamped

    angle_scoreboard board;
    int  idle_cycles = 0;
    bit  rx_busy_stretch;
    bit  tx_busy_stretch;

    quaternion_to_euler #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sends one quaternion after a random gap and waits for its transfer.
    // Valid stays high after the transfer; the next call or the caller drops it.
    task automatic send_quat(logic [15:0] qx, qy, qz, qw);
        int gap;
        gap = tx_busy_stretch ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {qw, qz, qy, qx};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_input({qw, qz, qy, qx});
    endtask

    // Random components: small values, raw bit patterns, near full-scale values.
    task automatic send_random();
        logic [15:0] c[4];
        int sel;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++) begin
            if (sel < 5) c[k] = 16'($signed($urandom_range(0, 23170)) - 11585);
            else if (sel < 8) c[k] = 16'($urandom);
            else c[k] = ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                        ^ 16'($urandom_range(0, 3));
        end
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    // Receiver: random stalls, with stretches of constant readiness.
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rx_busy_stretch ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_output(o_m_tdata, o_m_tuser);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int waited;
        board = new();
        rx_busy_stretch = 0;
        tx_busy_stretch = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, identity, extremes, gimbal lock, pi wrap.
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'h0000, 16'h5A82, 16'h0000, 16'h5A82);
        send_quat(16'h0000, 16'hA57E, 16'h0000, 16'h5A82);
        send_quat(16'h0000, 16'h5A81, 16'h0000, 16'h5A81);
        send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_quat(16'h0000, 16'h8000, 16'h0000, 16'h7FFF);
        send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);
        send_quat(16'h7FFF, 16'h0001, 16'h0000, 16'h0000);
        send_quat(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_quat(16'h4000, 16'h4000, 16'hC000, 16'h4000);
        i_s_tvalid <= 1'b0;

        // Sender pauses until the pipeline has drained.
        while (board.pending.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) begin
                rx_busy_stretch = ($urandom_range(0, 2) == 0);
                tx_busy_stretch = ($urandom_range(0, 2) == 0);
            end
            send_random();
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
